### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property shorthands; every use runs on i_clk and is disabled while
// i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define MGI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("port property violated");

// Next-cycle implication
`define MGI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("port property violated");

`endif

### design/mgi_pkg.sv
// ----------------------------------------------------------------------------
// mgi_pkg
// Types and fixed constants of the multilinear grid interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mgi_pkg;

    localparam int NUM_COORDS = 4;
    localparam int COORD_W    = 16;
    localparam int SIZE_W     = 9;
    localparam int DIMS_W     = 3;
    localparam int GIDX_W     = 12;
    localparam int VALUE_W    = 32;
    localparam int ACC_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    // Configuration register indexes
    localparam t_cfg_index CFG_NUM_DIMS = 3'd0;
    localparam t_cfg_index CFG_SIZE_0   = 3'd1;
    localparam t_cfg_index CFG_SIZE_1   = 3'd2;
    localparam t_cfg_index CFG_SIZE_2   = 3'd3;
    localparam t_cfg_index CFG_SIZE_3   = 3'd4;

    localparam logic [DIMS_W-1:0] NUM_DIMS_RESET = 3'd1;
    localparam logic [SIZE_W-1:0] SIZE_RESET     = 9'd2;

    // Input beat actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic                      action;
        logic [GIDX_W-1:0]         grid_index;
        logic signed [VALUE_W-1:0] grid_value;
        logic [COORD_W-1:0]        coord_0;
        logic [COORD_W-1:0]        coord_1;
        logic [COORD_W-1:0]        coord_2;
        logic [COORD_W-1:0]        coord_3;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] interp_value;
        logic                      range_error;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic                  write;
        logic                  capture;
        logic                  stride;
        logic                  base;
        logic                  issue;
        logic [NUM_COORDS-1:0] corner;
        logic                  load_out;
    } t_mgi_cmd;

    // Datapath to controller
    typedef struct packed {
        logic                  bad;
        logic [NUM_COORDS-1:0] last_corner;
        logic                  out_free;
    } t_mgi_stat;

endpackage

### design/mgi_stream_if.sv
// ----------------------------------------------------------------------------
// mgi_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mgi_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### design/mgi_ram.sv
// ----------------------------------------------------------------------------
// mgi_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mgi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/mgi_ctrl.sv
// ----------------------------------------------------------------------------
// mgi_ctrl
// Sequencer: accepts beats, steps query setup, walks the corners, drains the
// multiply pipeline and hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mgi_ctrl
    import mgi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_action,
    output logic      o_in_ready,
    input  t_mgi_stat i_stat,
    output t_mgi_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STRIDE,
        S_BASE,
        S_RUN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state                r_state, n_state;
    logic [NUM_COORDS-1:0] r_corner, n_corner;
    logic                  r_drain, n_drain;
    logic                  accept;

    // Decode commands from the current state
    always_comb begin
        o_in_ready      = (r_state == S_IDLE);
        accept          = i_in_valid && o_in_ready;
        o_cmd           = '0;
        o_cmd.write     = accept && (i_in_action == ACT_WRITE);
        o_cmd.capture   = accept && (i_in_action == ACT_QUERY);
        o_cmd.stride    = (r_state == S_STRIDE);
        o_cmd.base      = (r_state == S_BASE);
        o_cmd.issue     = (r_state == S_RUN);
        o_cmd.corner    = r_corner;
        o_cmd.load_out  = (r_state == S_FINISH) && i_stat.out_free;
    end

    // Next state
    always_comb begin
        n_state  = r_state;
        n_corner = r_corner;
        n_drain  = r_drain;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = S_STRIDE;
                end
            end
            S_STRIDE: begin
                n_state = S_BASE;
            end
            S_BASE: begin
                n_corner = '0;
                n_state  = i_stat.bad ? S_FINISH : S_RUN;
            end
            S_RUN: begin
                if (r_corner == i_stat.last_corner) begin
                    n_state = S_DRAIN;
                    n_drain = 1'b0;
                end else begin
                    n_corner = r_corner + 1'b1;
                end
            end
            S_DRAIN: begin
                if (r_drain) begin
                    n_state = S_FINISH;
                end
                n_drain = 1'b1;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_corner <= '0;
            r_drain  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_corner <= n_corner;
            r_drain  <= n_drain;
        end
    end

endmodule

### design/mgi_datapath.sv
// ----------------------------------------------------------------------------
// mgi_datapath
// Configuration registers, query setup, grid store, corner weight and
// multiply-accumulate pipeline, rounding and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mgi_datapath
    import mgi_pkg::*;
#(
    parameter int MAX_DIMS   = 4,
    parameter int GRID_DEPTH = 4096,
    parameter int FRAC_BITS  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_item,
    input  t_mgi_cmd              i_cmd,
    output t_mgi_stat             o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_out_item             o_out_item
);

    localparam int AW      = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
    localparam int SA_W    = AW + 1;
    localparam int LO_W    = (COORD_W > FRAC_BITS) ? COORD_W - FRAC_BITS : 1;
    localparam int FW      = FRAC_BITS + 1;
    localparam int PW      = 2 * FW;
    localparam int WW_FULL = 4 * FRAC_BITS + 1;
    localparam int WW      = (WW_FULL > ACC_W) ? ACC_W : WW_FULL;
    localparam int PRD_W   = VALUE_W + WW + 1;
    localparam int ONE     = 1 << FRAC_BITS;
    localparam int S2_W    = 2 * SIZE_W;
    localparam int S3_W    = 3 * SIZE_W;
    localparam int S4_W    = 4 * SIZE_W;

    // Configuration
    logic [DIMS_W-1:0] r_num_dims;
    logic [SIZE_W-1:0] r_size [NUM_COORDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= NUM_DIMS_RESET;
            for (int k = 0; k < NUM_COORDS; k++) begin
                r_size[k] <= SIZE_RESET;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM_DIMS: r_num_dims <= i_cfg_data[DIMS_W-1:0];
                CFG_SIZE_0:   r_size[0]  <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_1:   r_size[1]  <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_2:   r_size[2]  <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_3:   r_size[3]  <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Dimensions in use; unused dimensions act as size one
    logic                  dims_ok;
    logic [NUM_COORDS-1:0] dim_use;
    logic [SIZE_W-1:0]     s_eff [NUM_COORDS];

    always_comb begin
        dims_ok = (r_num_dims != '0) && (32'(r_num_dims) <= MAX_DIMS)
                  && (32'(r_num_dims) <= NUM_COORDS);
        for (int k = 0; k < NUM_COORDS; k++) begin
            dim_use[k] = dims_ok && (k < 32'(r_num_dims));
            s_eff[k]   = dim_use[k] ? r_size[k] : SIZE_W'(1);
        end
    end

    // Capture: split coordinates, check range, first size products
    logic [COORD_W-1:0]   coord [NUM_COORDS];
    logic                 cap_bad;
    logic [LO_W-1:0]      lo_n     [NUM_COORDS];
    logic [FW-1:0]        fac_lo_n [NUM_COORDS];
    logic [FW-1:0]        fac_hi_n [NUM_COORDS];
    logic [FRAC_BITS-1:0] frac     [NUM_COORDS];
    logic [31:0]          limit    [NUM_COORDS];

    assign coord[0] = i_item.coord_0;
    assign coord[1] = i_item.coord_1;
    assign coord[2] = i_item.coord_2;
    assign coord[3] = i_item.coord_3;

    always_comb begin
        cap_bad = !dims_ok;
        for (int k = 0; k < NUM_COORDS; k++) begin
            frac[k]  = coord[k][FRAC_BITS-1:0];
            limit[k] = 32'(r_size[k] - SIZE_W'(1)) << FRAC_BITS;
            if (dim_use[k] && ((r_size[k] == '0) || (32'(coord[k]) > limit[k]))) begin
                cap_bad = 1'b1;
            end
            lo_n[k]     = dim_use[k] ? LO_W'(32'(coord[k]) >> FRAC_BITS) : '0;
            fac_lo_n[k] = dim_use[k] ? (FW'(ONE) - FW'(frac[k])) : FW'(1);
            fac_hi_n[k] = dim_use[k] ? FW'(frac[k]) : '0;
        end
    end

    logic [LO_W-1:0] r_lo     [NUM_COORDS];
    logic [FW-1:0]   r_fac_lo [NUM_COORDS];
    logic [FW-1:0]   r_fac_hi [NUM_COORDS];
    logic            r_bad0;
    logic [S2_W-1:0] r_s01, r_s23;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int k = 0; k < NUM_COORDS; k++) begin
                r_lo[k]     <= lo_n[k];
                r_fac_lo[k] <= fac_lo_n[k];
                r_fac_hi[k] <= fac_hi_n[k];
            end
            r_bad0 <= cap_bad;
            r_s01  <= S2_W'(s_eff[0]) * S2_W'(s_eff[1]);
            r_s23  <= S2_W'(s_eff[2]) * S2_W'(s_eff[3]);
        end
    end

    // Strides and grid total
    logic [S3_W-1:0]   r_str0;
    logic [S2_W-1:0]   r_str1;
    logic [SIZE_W-1:0] r_str2;
    logic [S4_W-1:0]   r_total;

    always_ff @(posedge i_clk) begin
        if (i_cmd.stride) begin
            r_str0  <= S3_W'(s_eff[1]) * S3_W'(r_s23);
            r_str1  <= r_s23;
            r_str2  <= s_eff[3];
            r_total <= S4_W'(r_s01) * S4_W'(r_s23);
        end
    end

    assign o_stat.bad = r_bad0 || (r_total > S4_W'(GRID_DEPTH));
    assign o_stat.last_corner = NUM_COORDS'((32'd1 << r_num_dims) - 32'd1);

    // Base address, pair weights and pair address offsets
    logic            r_bad;
    logic [SA_W-1:0] r_base;
    logic [PW-1:0]   r_w01 [4];
    logic [PW-1:0]   r_w23 [4];
    logic [SA_W-1:0] r_a01 [4];
    logic [SA_W-1:0] r_a23 [4];

    always_ff @(posedge i_clk) begin
        if (i_cmd.base) begin
            r_bad  <= o_stat.bad;
            r_base <= SA_W'(32'(r_lo[0]) * 32'(r_str0) + 32'(r_lo[1]) * 32'(r_str1)
                            + 32'(r_lo[2]) * 32'(r_str2) + 32'(r_lo[3]));
            for (int j = 0; j < 4; j++) begin
                r_w01[j] <= PW'(j[0] ? r_fac_hi[0] : r_fac_lo[0])
                          * PW'(j[1] ? r_fac_hi[1] : r_fac_lo[1]);
                r_w23[j] <= PW'(j[0] ? r_fac_hi[2] : r_fac_lo[2])
                          * PW'(j[1] ? r_fac_hi[3] : r_fac_lo[3]);
                r_a01[j] <= (j[0] ? SA_W'(r_str0) : '0) + (j[1] ? SA_W'(r_str1) : '0);
                r_a23[j] <= (j[0] ? SA_W'(r_str2) : '0) + (j[1] ? SA_W'(1) : '0);
            end
        end
    end

    // Corner stage 0: address, store read and weight product
    logic [1:0]        j01, j23;
    logic [SA_W-1:0]   rd_addr_full;
    logic              addr_ok;
    logic [2*PW-1:0]   w_full;
    logic              r_v1;
    logic [WW-1:0]     r_w;
    logic [VALUE_W-1:0] rd_data;
    logic              wr_ok;

    assign j01          = i_cmd.corner[1:0];
    assign j23          = i_cmd.corner[3:2];
    assign rd_addr_full = r_base + r_a01[j01] + r_a23[j23];
    assign addr_ok      = rd_addr_full < SA_W'(GRID_DEPTH);
    assign w_full       = (2*PW)'(r_w01[j01]) * (2*PW)'(r_w23[j23]);
    assign wr_ok        = i_cmd.write && (32'(i_item.grid_index) < GRID_DEPTH);

    mgi_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (GRID_DEPTH)
    ) u_grid_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_ok),
        .i_wr_addr (AW'(32'(i_item.grid_index))),
        .i_wr_data (i_item.grid_value),
        .i_rd_en   (i_cmd.issue),
        .i_rd_addr (rd_addr_full[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Corner stage 1: sample times weight; drop zero-weight corners
    logic signed [PRD_W-1:0] op_a, op_b, prod;
    logic                    r_v2;
    logic [ACC_W-1:0]        r_prod;
    logic [ACC_W-1:0]        r_acc;

    assign op_a = PRD_W'($signed(rd_data));
    assign op_b = PRD_W'({1'b0, r_w});
    assign prod = op_a * op_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue && addr_ok;
            r_v2 <= r_v1 && (r_w != '0);
        end
    end

    // Corner stage 2: accumulate modulo 2^64
    always_ff @(posedge i_clk) begin
        r_w    <= w_full[WW-1:0];
        r_prod <= ACC_W'(prod);
        if (i_cmd.capture) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + r_prod;
        end
    end

    // Round half up and take the low word
    logic [5:0]              sh;
    logic [ACC_W-1:0]        half;
    logic [ACC_W-1:0]        rounded;
    logic signed [ACC_W-1:0] shifted;

    always_comb begin
        sh = '0;
        for (int k = 1; k <= NUM_COORDS; k++) begin
            if (32'(r_num_dims) == k) begin
                sh = 6'(FRAC_BITS * k);
            end
        end
        half    = (sh != '0) ? (ACC_W'(1) << (sh - 6'd1)) : '0;
        rounded = r_acc + half;
        shifted = $signed(rounded) >>> sh;
    end

    // Output register
    logic      r_out_valid;
    t_out_item r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_item.interp_value <= r_bad ? '0 : shifted[VALUE_W-1:0];
            r_out_item.range_error  <= r_bad;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out_item;

endmodule

### design/multilinear_grid_interpolator.sv
// ----------------------------------------------------------------------------
// multilinear_grid_interpolator
// Multilinear interpolation over a row-major grid of one to four dimensions.
// ----------------------------------------------------------------------------
// Write beats (action 0) fill the grid store and return nothing; the input
// stays ready. A query beat (action 1) returns one result, d being num_dims:
// a capture step, setup of the strides and then of the base address and pair
// weights, one corner per cycle for all 2^d corners through the single read
// port of the grid store, a drain of the multiply-accumulate pipeline, and a
// final step that rounds and loads the output register once it is free. A
// rejected query skips the corner walk. The input is held off while a query
// is in flight; a finished result waits in the output register without
// blocking further writes.
// The grid store comes up undefined; only read entries that were written.
// Configuration writes are only legal while no query is in flight.
`timescale 1ns / 1ps

module multilinear_grid_interpolator
    import mgi_pkg::*;
#(
    parameter int MAX_DIMS   = 4,
    parameter int GRID_DEPTH = 4096,
    parameter int FRAC_BITS  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mgi_stream_if.sink            i_in,
    mgi_stream_if.source          o_out
);

    t_mgi_cmd  cmd;
    t_mgi_stat stat;
    t_in_item  in_item;
    t_out_item out_item;
    logic      in_ready;
    logic      out_valid;

    assign in_item       = i_in.payload;
    assign i_in.ready    = in_ready;
    assign o_out.valid   = out_valid;
    assign o_out.payload = out_item;

    mgi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (in_item.action),
        .o_in_ready  (in_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mgi_datapath #(
        .MAX_DIMS   (MAX_DIMS),
        .GRID_DEPTH (GRID_DEPTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_out_item  (out_item)
    );

endmodule

### design/mgi_checker.sv
// ----------------------------------------------------------------------------
// mgi_checker
// Port-level properties of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mgi_checker
    import mgi_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_in_action,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [VALUE_W-1:0] i_out_value,
    input logic               i_out_error
);

    // Hold a stalled result beat
    `MGI_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_value) && $stable(i_out_error))

    // A rejected query carries a zero value
    `MGI_ASSERT_IMPL(a_err_zero, i_out_valid && i_out_error, i_out_value == '0)

    // An accepted query keeps the input closed on the next cycle
    `MGI_ASSERT_NEXT(a_query_busy, i_in_valid && i_in_ready && (i_in_action == ACT_QUERY), !i_in_ready)

    // A new result only appears at the end of a query
    `MGI_ASSERT_IMPL(a_result_after_query, $rose(i_out_valid), $past(!i_in_ready))

endmodule

bind multilinear_grid_interpolator mgi_checker u_mgi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_action (i_in.payload.action),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.payload.interp_value),
    .i_out_error (o_out.payload.range_error)
);
